### sv/dds_pkg.sv
// Shared types and constants of the differential drive speed limiter.
// Used by the top level and by the quotient unit; depends on nothing.
package dds_pkg;

  // Configuration register map
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgAddrW-1:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_MAX_SPEED_STEP = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_MAX_TURN       = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_MAX_TURN_STEP  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_TREAD          = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_RADIUS_SUM     = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_COUNTS_PER_RAD = 3'd6;

  // Register values after reset
  localparam logic [CfgDataW-1:0] RST_MAX_SPEED      = 31'd65536;
  localparam logic [CfgDataW-1:0] RST_MAX_SPEED_STEP = 31'd6554;
  localparam logic [CfgDataW-1:0] RST_MAX_TURN       = 31'd131072;
  localparam logic [CfgDataW-1:0] RST_MAX_TURN_STEP  = 31'd13107;
  localparam logic [CfgDataW-1:0] RST_TREAD          = 31'd26214;
  localparam logic [CfgDataW-1:0] RST_RADIUS_SUM     = 31'd6554;
  localparam logic [CfgDataW-1:0] RST_COUNTS_PER_RAD = 31'd65536;

  // Quotient unit: two quotient bits per step, 32 quotient bits
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned DvdW     = 62;
  localparam int unsigned DvsW     = 31;
  localparam int unsigned QuotW    = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM_V,
    S_LIM_W,
    S_ROT,
    S_RSV,
    S_NUM,
    S_ABS,
    S_LO,
    S_HI,
    S_SUM,
    S_CHK,
    S_DIV,
    S_OUT
  } dds_state_e;

  // Status of the quotient unit
  typedef struct packed {
    logic busy;
    logic done;
  } dds_div_stat_t;

endpackage

### sv/diff_drive_speed_limiter_top.sv
// Differential drive speed limiter: limits a speed and turn command and
// derives wheel references. Depends on dds_pkg and instantiates dds_div.
//
// Each accepted command is clamped to its magnitude limit and then to one
// step limit of the previous applied value; the applied pair is kept as the
// new previous value and turned into right and left wheel references in
// whole encoder counts, (2v -/+ tread*w) * counts_per_rad / radius_sum,
// truncated toward zero and saturated to 32 bits. One shared 32x32
// multiplier and one divider that retires two quotient bits a cycle do the
// arithmetic under a sequencer. An item holds the input side from
// acceptance until its result enters the output register, and the next
// item can be taken in the following cycle; a wheel whose reference is
// zero or saturates skips its division. The divider, run once per wheel,
// takes most of the time an item holds the input side. The output register frees
// the input side while a result waits to be taken. Configuration is written
// through a plain write port and must only change while the block is idle.
module diff_drive_speed_limiter_top import dds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  speed_cmd_i,
  input  logic signed [31:0]  turn_cmd_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  right_ref_o,
  output logic signed [31:0]  left_ref_o,
  output logic [3:0]          clamp_flags_o,
  output logic signed [31:0]  applied_speed_o,
  output logic signed [31:0]  applied_turn_o,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [CfgDataW-1:0] max_speed_q, max_speed_step_q, max_turn_q, max_turn_step_q;
  logic [CfgDataW-1:0] tread_q, radius_sum_q, counts_per_rad_q;

  // Control state
  dds_state_e         state_q, state_d;
  logic               wheel_q;
  logic               out_valid_q;
  logic signed [31:0] prev_speed_q, prev_turn_q;

  // Working payload
  logic signed [31:0] cmd_v_q, cmd_w_q;
  logic [3:0]         flags_q;
  logic [63:0]        prod_q;
  logic signed [63:0] rot_q, num_q;
  logic [62:0]        mag_q;
  logic               neg_q;
  logic [30:0]        plo_q;
  logic [61:0]        hi_q;
  logic signed [31:0] right_q, left_q;

  // Output register
  logic signed [31:0] out_right_q, out_left_q, out_speed_q, out_turn_q;
  logic [3:0]         out_flags_q;

  // Sequencer outputs
  logic               in_fire, out_load, div_start, wheel_wr;
  logic signed [31:0] wheel_res;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Divider
  logic [QuotW-1:0] div_quot;
  dds_div_stat_t    div_stat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Write configuration registers; ignore the unused index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q      <= RST_MAX_SPEED;
      max_speed_step_q <= RST_MAX_SPEED_STEP;
      max_turn_q       <= RST_MAX_TURN;
      max_turn_step_q  <= RST_MAX_TURN_STEP;
      tread_q          <= RST_TREAD;
      radius_sum_q     <= RST_RADIUS_SUM;
      counts_per_rad_q <= RST_COUNTS_PER_RAD;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MAX_SPEED:      max_speed_q      <= cfg_wdata_i;
        REG_MAX_SPEED_STEP: max_speed_step_q <= cfg_wdata_i;
        REG_MAX_TURN:       max_turn_q       <= cfg_wdata_i;
        REG_MAX_TURN_STEP:  max_turn_step_q  <= cfg_wdata_i;
        REG_TREAD:          tread_q          <= cfg_wdata_i;
        REG_RADIUS_SUM:     radius_sum_q     <= cfg_wdata_i;
        REG_COUNTS_PER_RAD: counts_per_rad_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Limiter, shared between the speed and the turn channel
  logic               lim_sel_v;
  logic signed [33:0] lx, lm, ls, lp, lx1, lhi, llo, lx2;
  logic signed [31:0] lim_res;
  logic               lim_mag_f, lim_step_f;

  always_comb begin
    lim_sel_v  = (state_q == S_LIM_V);
    lx  = lim_sel_v ? {{2{cmd_v_q[31]}}, cmd_v_q} : {{2{cmd_w_q[31]}}, cmd_w_q};
    lm  = lim_sel_v ? {3'b000, max_speed_q} : {3'b000, max_turn_q};
    ls  = lim_sel_v ? {3'b000, max_speed_step_q} : {3'b000, max_turn_step_q};
    lp  = lim_sel_v ? {{2{prev_speed_q[31]}}, prev_speed_q}
                    : {{2{prev_turn_q[31]}}, prev_turn_q};
    lhi = lp + ls;
    llo = lp - ls;
    lim_mag_f  = 1'b0;
    lim_step_f = 1'b0;
    // Clamp the magnitude
    if (lx > lm) begin
      lx1       = lm;
      lim_mag_f = 1'b1;
    end else if (lx < -lm) begin
      lx1       = -lm;
      lim_mag_f = 1'b1;
    end else begin
      lx1 = lx;
    end
    // Clamp the change against the previous applied value
    if (lx1 > lhi) begin
      lx2        = lhi;
      lim_step_f = 1'b1;
    end else if (lx1 < llo) begin
      lx2        = llo;
      lim_step_f = 1'b1;
    end else begin
      lx2 = lx1;
    end
    // Saturate to 32 bits
    if (lx2 > 34'sd2147483647) begin
      lim_res = 32'sh7FFF_FFFF;
    end else if (lx2 < -34'sd2147483648) begin
      lim_res = 32'sh8000_0000;
    end else begin
      lim_res = lx2[31:0];
    end
  end

  // Turn rate magnitude for the tread product
  logic [32:0] w_neg;
  logic [31:0] w_mag;
  assign w_neg = 33'd0 - {prev_turn_q[31], prev_turn_q};
  assign w_mag = prev_turn_q[31] ? w_neg[31:0] : prev_turn_q;

  // Select multiplier operands by step
  always_comb begin
    unique case (state_q)
      S_ROT: begin
        mul_a = w_mag;
        mul_b = {1'b0, tread_q};
      end
      S_LO: begin
        mul_a = mag_q[31:0];
        mul_b = {1'b0, counts_per_rad_q};
      end
      S_HI: begin
        mul_a = {1'b0, mag_q[62:32]};
        mul_b = {1'b0, counts_per_rad_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Numerator terms
  logic signed [63:0] lin, rot_pos, rot_neg, num_abs;
  assign lin     = {{15{prev_speed_q[31]}}, prev_speed_q, 17'b0};
  assign rot_pos = {2'b00, prod_q[61:0]};
  assign rot_neg = 64'sd0 - rot_pos;
  assign num_abs = 64'sd0 - num_q;

  // Short cuts for a zero product and an oversized quotient
  logic               ref_zero, ref_ovf;
  logic signed [31:0] ref_sat;
  logic [QuotW-1:0]   quot_neg;
  assign ref_zero = (mag_q == '0) || (counts_per_rad_q == '0);
  assign ref_ovf  = (hi_q[61:31] >= radius_sum_q);
  assign ref_sat  = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  assign quot_neg = '0 - div_quot;

  // Next state and sequencer strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    wheel_wr  = 1'b0;
    wheel_res = '0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_LIM_V;
      S_LIM_V: state_d = S_LIM_W;
      S_LIM_W: state_d = S_ROT;
      S_ROT:   state_d = S_RSV;
      S_RSV:   state_d = S_NUM;
      S_NUM:   state_d = S_ABS;
      S_ABS:   state_d = S_LO;
      S_LO:    state_d = S_HI;
      S_HI:    state_d = S_SUM;
      S_SUM:   state_d = S_CHK;
      S_CHK: begin
        priority if (ref_zero) begin
          wheel_wr  = 1'b1;
          wheel_res = '0;
        end else if (ref_ovf) begin
          wheel_wr  = 1'b1;
          wheel_res = ref_sat;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
        if (wheel_wr) state_d = wheel_q ? S_OUT : S_NUM;
      end
      S_DIV: begin
        if (div_stat.done) begin
          wheel_wr  = 1'b1;
          wheel_res = neg_q ? quot_neg : div_quot;
          state_d   = wheel_q ? S_OUT : S_NUM;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the state, wheel select, applied values and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wheel_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_speed_q <= '0;
      prev_turn_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        wheel_q <= 1'b0;
      end else if (wheel_wr) begin
        wheel_q <= ~wheel_q;
      end
      if (state_q == S_LIM_V) prev_speed_q <= lim_res;
      if (state_q == S_LIM_W) prev_turn_q  <= lim_res;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_v_q <= speed_cmd_i;
      cmd_w_q <= turn_cmd_i;
    end
    if (state_q == S_LIM_V) flags_q[1:0] <= {lim_step_f, lim_mag_f};
    if (state_q == S_LIM_W) flags_q[3:2] <= {lim_step_f, lim_mag_f};
    if (state_q == S_ROT || state_q == S_LO) prod_q <= mul_p;
    if (state_q == S_HI) begin
      plo_q  <= prod_q[62:32];
      prod_q <= mul_p;
    end
    if (state_q == S_RSV) rot_q <= prev_turn_q[31] ? rot_neg : rot_pos;
    if (state_q == S_NUM) num_q <= wheel_q ? (lin + rot_q) : (lin - rot_q);
    if (state_q == S_ABS) begin
      neg_q <= num_q[63];
      mag_q <= num_q[63] ? num_abs[62:0] : num_q[62:0];
    end
    if (state_q == S_SUM) hi_q <= prod_q[61:0] + {31'b0, plo_q};
    if (wheel_wr) begin
      if (wheel_q) begin
        left_q <= wheel_res;
      end else begin
        right_q <= wheel_res;
      end
    end
    if (out_load) begin
      out_right_q <= right_q;
      out_left_q  <= left_q;
      out_flags_q <= flags_q;
      out_speed_q <= prev_speed_q;
      out_turn_q  <= prev_turn_q;
    end
  end

  dds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hi_q),
    .divisor_i  (radius_sum_q),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  assign out_valid_o     = out_valid_q;
  assign right_ref_o     = out_right_q;
  assign left_ref_o      = out_left_q;
  assign clamp_flags_o   = out_flags_q;
  assign applied_speed_o = out_speed_q;
  assign applied_turn_o  = out_turn_q;

`ifndef NO_ASSERTIONS
  // An accepted beat always starts with the speed limiter
  a_accept_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_LIM_V))
    else $error("command beat did not start the limiter");

  // The divider runs only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == S_DIV))
    else $error("divider active outside its wait state");

  // A new result appears only from the output step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result valid rose outside the output step");
`endif

endmodule

### sv/dds_div.sv
// Restoring divider, two quotient bits per cycle, for the wheel references.
// Depends on dds_pkg for widths and the status struct.
module dds_div import dds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DvdW-1:0]      dividend_i,
  input  logic [DvsW-1:0]      divisor_i,
  output logic [QuotW-1:0]     quot_o,
  output dds_div_stat_t        stat_o
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivSteps - 1);

  logic [DvsW-1:0]    rem_q, rem_d;
  logic [QuotW-1:0]   sh_q, sh_d;
  logic [DvsW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  logic [DvsW:0]      t1, t2, dvs_ext, t1_sub, t2_sub;
  logic               ge1, ge2;
  logic [DvsW-1:0]    r1;

  // Two chained compare-and-subtract steps
  always_comb begin
    dvs_ext = {1'b0, dvs_q};
    t1      = {rem_q, sh_q[QuotW-1]};
    ge1     = (t1 >= dvs_ext);
    t1_sub  = t1 - dvs_ext;
    r1      = ge1 ? t1_sub[DvsW-1:0] : t1[DvsW-1:0];
    t2      = {r1, sh_q[QuotW-2]};
    ge2     = (t2 >= dvs_ext);
    t2_sub  = t2 - dvs_ext;
    rem_d   = ge2 ? t2_sub[DvsW-1:0] : t2[DvsW-1:0];
    sh_d    = {sh_q[QuotW-3:0], ge1, ge2};
  end

  // Load on start, then shift dividend bits out and quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[DvdW-1:QuotW]};
      sh_q  <= dividend_i[QuotW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  // Step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = sh_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef NO_ASSERTIONS
  // Partial remainder stays below the divisor through the whole division
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder reached the divisor");

  // A start always opens a division
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && !done_q))
    else $error("divider did not start");

  // Done pulses only once the step count has run out
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q) && $past(cnt_q) == LastStep))
    else $error("divider done without a full step count");
`endif

endmodule

### verif/dds_limiter_checker.sv
// Checker of the differential drive speed limiter: mirrors the register file,
// predicts limited commands and wheel references, compares result beats.
// Depends on dds_pkg for the register map and reset values.
`timescale 1ns / 1ps

module dds_limiter_checker import dds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [31:0]  speed_cmd_i,
  input  logic signed [31:0]  turn_cmd_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [31:0]  right_ref_i,
  input  logic signed [31:0]  left_ref_i,
  input  logic [3:0]          clamp_flags_i,
  input  logic signed [31:0]  applied_speed_i,
  input  logic signed [31:0]  applied_turn_i,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);

  localparam logic [3:0] FLAG_SPEED_MAG  = 4'b0001;
  localparam logic [3:0] FLAG_SPEED_STEP = 4'b0010;
  localparam logic [3:0] FLAG_TURN_MAG   = 4'b0100;
  localparam logic [3:0] FLAG_TURN_STEP  = 4'b1000;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic signed [31:0] right_ref;
    logic signed [31:0] left_ref;
    logic [3:0]         clamp_flags;
    logic signed [31:0] speed;
    logic signed [31:0] turn;
  } wheel_refs_t;

  // Mirror of the register file
  logic [CfgDataW-1:0] max_speed_r, max_speed_step_r, max_turn_r, max_turn_step_r;
  logic [CfgDataW-1:0] tread_r, radius_sum_r, counts_per_rad_r;

  // Last applied command pair
  longint last_speed, last_turn;

  wheel_refs_t pending_refs_q[$];
  int mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, predicted %h", name, got, want));
    end
  endtask

  // Clamp to magnitude, then to one step of the previous value
  function automatic longint clamp_axis(input longint cmd, input longint lim,
                                        input longint step, input longint prev,
                                        output logic mag_hit, output logic step_hit);
    longint x;
    x = cmd;
    mag_hit = 1'b0;
    step_hit = 1'b0;
    if (x > lim) begin
      x = lim;
      mag_hit = 1'b1;
    end else if (x < -lim) begin
      x = -lim;
      mag_hit = 1'b1;
    end
    if (x > prev + step) begin
      x = prev + step;
      step_hit = 1'b1;
    end else if (x < prev - step) begin
      x = prev - step;
      step_hit = 1'b1;
    end
    if (x > S32_MAX) x = S32_MAX;
    if (x < S32_MIN) x = S32_MIN;
    return x;
  endfunction

  // num * counts_per_rad / (radius_sum * 2^32), truncated toward zero, saturated
  function automatic logic signed [31:0] wheel_counts(input longint num);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] quo;
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    prod = 128'(mag) * 128'(counts_per_rad_r);
    if (radius_sum_r == '0) begin
      if (prod == '0) return 32'sd0;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    quo = (prod >> 32) / 128'(radius_sum_r);
    if (neg) begin
      if (quo >= 128'h8000_0000) return 32'sh8000_0000;
      return 32'd0 - quo[31:0];
    end
    if (quo > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return quo[31:0];
  endfunction

  // Limit one command pair, advance the stored pair, derive wheel references
  function automatic wheel_refs_t wheel_refs_for(input logic signed [31:0] speed_cmd,
                                                 input logic signed [31:0] turn_cmd);
    wheel_refs_t res;
    logic        sm, ss, tm, ts;
    longint      v, w, lin, rot;
    v = clamp_axis(longint'(speed_cmd), longint'(max_speed_r),
                   longint'(max_speed_step_r), last_speed, sm, ss);
    w = clamp_axis(longint'(turn_cmd), longint'(max_turn_r),
                   longint'(max_turn_step_r), last_turn, tm, ts);
    last_speed = v;
    last_turn = w;
    lin = v * 64'sd131072;
    rot = longint'(tread_r) * w;
    res.right_ref = wheel_counts(lin - rot);
    res.left_ref = wheel_counts(lin + rot);
    res.clamp_flags = (sm ? FLAG_SPEED_MAG : 4'b0) | (ss ? FLAG_SPEED_STEP : 4'b0) |
                      (tm ? FLAG_TURN_MAG : 4'b0) | (ts ? FLAG_TURN_STEP : 4'b0);
    res.speed = 32'(v);
    res.turn = 32'(w);
    return res;
  endfunction

  task automatic check_result_beat();
    wheel_refs_t want;
    if (pending_refs_q.size() == 0) begin
      report_mismatch("result beat with no command outstanding");
    end else begin
      want = pending_refs_q.pop_front();
      check_field("right_ref", right_ref_i, want.right_ref);
      check_field("left_ref", left_ref_i, want.left_ref);
      check_field("clamp_flags", 32'(clamp_flags_i), 32'(want.clamp_flags));
      check_field("applied_speed", applied_speed_i, want.speed);
      check_field("applied_turn", applied_turn_i, want.turn);
    end
  endtask

  // Track register writes, predict on command beats, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_r      = RST_MAX_SPEED;
      max_speed_step_r = RST_MAX_SPEED_STEP;
      max_turn_r       = RST_MAX_TURN;
      max_turn_step_r  = RST_MAX_TURN_STEP;
      tread_r          = RST_TREAD;
      radius_sum_r     = RST_RADIUS_SUM;
      counts_per_rad_r = RST_COUNTS_PER_RAD;
      last_speed = 0;
      last_turn = 0;
      pending_refs_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MAX_SPEED:      max_speed_r      = cfg_wdata_i;
          REG_MAX_SPEED_STEP: max_speed_step_r = cfg_wdata_i;
          REG_MAX_TURN:       max_turn_r       = cfg_wdata_i;
          REG_MAX_TURN_STEP:  max_turn_step_r  = cfg_wdata_i;
          REG_TREAD:          tread_r          = cfg_wdata_i;
          REG_RADIUS_SUM:     radius_sum_r     = cfg_wdata_i;
          REG_COUNTS_PER_RAD: counts_per_rad_r = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_refs_q.push_back(wheel_refs_for(speed_cmd_i, turn_cmd_i));
      end
      if (out_valid_i && out_ready_i) begin
        check_result_beat();
      end
      outstanding_o <= pending_refs_q.size();
    end
  end

endmodule

### verif/testbench.sv
// Top of the speed limiter testbench: clock, reset, command and register
// stimulus, and the verdict. Depends on dds_pkg and dds_limiter_checker.
`timescale 1ns / 1ps

module testbench;
  import dds_pkg::*;

  localparam logic [CfgAddrW-1:0] REG_UNMAPPED = 3'd7;
  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 86;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [31:0]  speed_cmd_i = '0;
  logic signed [31:0]  turn_cmd_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [31:0]  right_ref_o, left_ref_o, applied_speed_o, applied_turn_o;
  logic [3:0]          clamp_flags_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int mismatches, outstanding;
  int idle_pct = 7;
  int commands_sent = 0;
  int settings_used = 1;

  // Register values as last written, used to aim commands near the limits
  logic [CfgDataW-1:0] cfg_val [0:6] = '{RST_MAX_SPEED, RST_MAX_SPEED_STEP,
                                         RST_MAX_TURN, RST_MAX_TURN_STEP, RST_TREAD,
                                         RST_RADIUS_SUM, RST_COUNTS_PER_RAD};

  always #10 clk_i = ~clk_i;

  diff_drive_speed_limiter_top u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .speed_cmd_i, .turn_cmd_i,
    .out_valid_o, .out_ready_i, .right_ref_o, .left_ref_o, .clamp_flags_o,
    .applied_speed_o, .applied_turn_o,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  dds_limiter_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .speed_cmd_i, .turn_cmd_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .right_ref_i(right_ref_o), .left_ref_i(left_ref_o), .clamp_flags_i(clamp_flags_o),
    .applied_speed_i(applied_speed_o), .applied_turn_i(applied_turn_o),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Timeout waiting for the limiter to finish");
    $display("Mismatches found");
    $finish;
  end

  task automatic set_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    if (idx <= REG_COUNTS_PER_RAD) cfg_val[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic cfg_done();
    cfg_we_i <= 1'b0;
    settings_used++;
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic [CfgDataW-1:0] ms, mss, mt, mts, tr, rs, cpr);
    set_reg(REG_MAX_SPEED, ms);
    set_reg(REG_MAX_SPEED_STEP, mss);
    set_reg(REG_MAX_TURN, mt);
    set_reg(REG_MAX_TURN_STEP, mts);
    set_reg(REG_TREAD, tr);
    set_reg(REG_RADIUS_SUM, rs);
    set_reg(REG_COUNTS_PER_RAD, cpr);
    cfg_done();
  endtask

  // Drive one command beat and hold it until taken
  task automatic send(input logic signed [31:0] speed, input logic signed [31:0] turn);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    speed_cmd_i <= speed;
    turn_cmd_i <= turn;
    do @(posedge clk_i); while (!in_ready_o);
    commands_sent++;
  endtask

  // Hold the command side until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] random_reg();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return CfgDataW'($urandom_range(1, 1 << 16));
      4:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1 << 12, 1 << 18));
    endcase
  endfunction

  // Commands: raw words, values near the limit, values up to an eighth past it, small ones
  function automatic logic signed [31:0] pick_cmd(input logic [CfgDataW-1:0] lim);
    longint v;
    case ($urandom_range(0, 3))
      0:       v = longint'($signed($urandom));
      1:       v = longint'(lim) + longint'($urandom_range(0, 4)) - 64'sd2;
      2:       v = longint'($urandom) % (longint'(lim) + longint'(lim >> 3) + 64'sd1);
      default: v = longint'($urandom_range(0, 1 << 18));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: exact step, step clamps, magnitude plus step clamps
    send(32'sd0, 32'sd0);
    send(32'sd6554, 32'sd13107);
    send(32'sd20000, -32'sd40000);
    send(32'sh7FFF_FFFF, 32'sh8000_0000);
    send(32'sh8000_0000, 32'sh7FFF_FFFF);
    drain();

    // Unbounded steps: values exactly at and just past the magnitude limit
    set_all(31'd65536, 31'h7FFF_FFFF, 31'd131072, 31'h7FFF_FFFF,
            RST_TREAD, RST_RADIUS_SUM, RST_COUNTS_PER_RAD);
    send(32'sd65536, -32'sd131072);
    send(-32'sd65537, 32'sd131073);
    send(-32'sd65536, 32'sd131072);
    drain();

    // Widest registers with the smallest divisor: full-scale commands saturate
    set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
            31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
    send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(32'sh8000_0000, 32'sh8000_0000);
    send(32'sh7FFF_FFFF, 32'sh8000_0000);
    send(32'sd1, 32'sd0);
    send(32'sd0, -32'sd1);
    send(32'sd0, 32'sd0);
    drain();

    // Zero divisor: zero product gives zero, anything else saturates by sign
    set_reg(REG_RADIUS_SUM, '0);
    set_reg(REG_COUNTS_PER_RAD, 31'd65536);
    set_reg(REG_UNMAPPED, 31'h5A5A_A5A5);
    cfg_done();
    send(32'sd0, 32'sd0);
    send(32'sd65536, 32'sd0);
    send(-32'sd65536, 32'sd0);
    drain();
    set_reg(REG_COUNTS_PER_RAD, '0);
    cfg_done();
    send(32'sd1000, -32'sd1000);
    drain();

    // Zero magnitude limits and zero tread
    set_reg(REG_MAX_SPEED, '0);
    set_reg(REG_MAX_TURN, '0);
    set_reg(REG_TREAD, '0);
    set_reg(REG_RADIUS_SUM, 31'd1);
    set_reg(REG_COUNTS_PER_RAD, 31'd65536);
    cfg_done();
    send(32'sd12345, -32'sd6789);
    drain();

    // Random phases, each under freshly drawn registers
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r <= int'(REG_COUNTS_PER_RAD); r++) begin
        set_reg(CfgAddrW'(r), random_reg());
      end
      cfg_done();
      idle_pct = (p == 3) ? 0 : 7;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 2 && k == ITEMS_PER_PHASE / 2) drain();
        send(pick_cmd(cfg_val[REG_MAX_SPEED]), pick_cmd(cfg_val[REG_MAX_TURN]));
      end
      drain();
    end
    idle_pct = 7;

    repeat (60) @(posedge clk_i);
    $display("Covered %0d commands under %0d register settings", commands_sent,
             settings_used);
    $display("incl. magnitude/step clamps, saturated and zero-divisor wheel references");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
